### src/ros_pkg.sv
// ----------------------------------------------------------------------------
// ros_pkg
// Shared types and constants of the RPN operand stack: item layouts,
// function codes and the per-cell shift controls.
// ----------------------------------------------------------------------------
package ros_pkg;

	localparam int DEPTH     = 16;
	localparam int WORD_BITS = 64;
	localparam int FUNC_W    = 4;
	localparam int POS_W     = 5;
	localparam int CFG_W     = 5;
	localparam int FIELD_W   = 64;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH    = 4'd0,
		FN_POP     = 4'd1,
		FN_GET_TOP = 4'd2,
		FN_GET_BOT = 4'd3,
		FN_ROT_UP  = 4'd4,
		FN_ROT_DN  = 4'd5,
		FN_EXCH    = 4'd6,
		FN_DEL_TOP = 4'd7,
		FN_DEL_BOT = 4'd8
	} ros_func_t;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_UP   = 2'd1,
		CELL_DOWN = 2'd2,
		CELL_LOAD = 2'd3
	} ros_cell_op_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_SHIFT = 1'b1
	} ros_state_t;

	typedef struct packed {
		ros_func_t          func;
		logic [FIELD_W-1:0] push_value;
		logic [POS_W-1:0]   position;
	} ros_req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] read_value;
		logic               ok;
		logic [POS_W-1:0]   count;
	} ros_rsp_t;

	typedef struct packed {
		ros_cell_op_t [DEPTH-1:0] op;
		logic [IDX_W-1:0]         rd_idx;
		logic [WORD_BITS-1:0]     load_word;
	} ros_row_ctrl_t;

endpackage

### src/rpn_operand_stack.sv
// ----------------------------------------------------------------------------
// rpn_operand_stack
// Bounded operand stack for an RPN calculator, built as a row of cells.
// ----------------------------------------------------------------------------
// Every function ends on acceptance, but delete from bottom with n entries
// removed (0 < n < count) then moves the stack down one place per cycle for
// n places while new items stall. An item's result is known on acceptance
// and goes into a two-entry output queue, so a new item is taken while an
// earlier result still waits. The user writes the max_depth register through
// the cfg channel only while no item is in flight; the block does not check.
module rpn_operand_stack import ros_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  ros_req_t         req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output ros_rsp_t         rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	function automatic logic [CNT_W-1:0] lim_of(input logic [CFG_W-1:0] md);
		if (md == '0 || int'(md) > DEPTH)
			return CNT_W'(DEPTH);
		return CNT_W'(md);
	endfunction

	ros_state_t           state_q, state_nxt;
	logic [CFG_W-1:0]     max_depth_q;
	logic [CNT_W-1:0]     held_q, held_nxt;
	logic [CNT_W-1:0]     shift_q;
	logic [1:0]           occ_q;
	ros_rsp_t             head_q, tail_q;
	ros_rsp_t             rsp_nxt;
	ros_row_ctrl_t        ctrl;
	logic [WORD_BITS-1:0] rd_word;
	logic [CNT_W-1:0]     lim, held_m1, held_m2, new_lim;
	logic [CMP_W-1:0]     pos_c, held_c;
	logic                 req_acc, rsp_acc, cfg_acc;
	logic                 pos_out, start_shift;

	assign req_acc = req_valid && !req_stall;
	assign rsp_acc = rsp_valid && !rsp_stall;
	assign cfg_acc = cfg_valid && cfg_ready;

	assign lim     = lim_of(max_depth_q);
	assign new_lim = lim_of(cfg_data);
	assign held_m1 = held_q - CNT_W'(1);
	assign held_m2 = held_q - CNT_W'(2);
	assign pos_c   = CMP_W'(req.position);
	assign held_c  = CMP_W'(held_q);
	assign pos_out = pos_c >= held_c;

	assign start_shift = req_acc && req.func == FN_DEL_BOT && !pos_out && pos_c != '0;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (start_shift) state_nxt = ST_SHIFT;
			ST_SHIFT: if (shift_q == CNT_W'(1)) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		unique case (state_q)
			ST_IDLE: begin
				req_stall = occ_q == 2'd2;
				cfg_ready = 1'b1;
			end
			ST_SHIFT: begin
				req_stall = 1'b1;
				cfg_ready = 1'b0;
			end
			default: begin
				req_stall = 1'b1;
				cfg_ready = 1'b0;
			end
		endcase
	end

	// cell controls, result and next count
	always_comb begin
		for (int i = 0; i < DEPTH; i++)
			ctrl.op[i] = CELL_HOLD;
		ctrl.rd_idx    = IDX_W'(held_m1);
		ctrl.load_word = req.push_value[WORD_BITS-1:0];
		held_nxt       = held_q;
		rsp_nxt.ok         = 1'b1;
		rsp_nxt.read_value = '0;

		if (state_q == ST_SHIFT) begin
			for (int i = 0; i < DEPTH; i++)
				ctrl.op[i] = CELL_UP;
		end else if (req_acc) begin
			unique case (req.func)
				FN_PUSH: begin
					if (held_q >= lim) begin
						for (int i = 0; i < DEPTH; i++) begin
							if (CNT_W'(i) == lim - CNT_W'(1))
								ctrl.op[i] = CELL_LOAD;
							else if (CNT_W'(i) < lim)
								ctrl.op[i] = CELL_UP;
						end
						held_nxt = lim;
					end else begin
						for (int i = 0; i < DEPTH; i++)
							if (CNT_W'(i) == held_q)
								ctrl.op[i] = CELL_LOAD;
						held_nxt = held_q + CNT_W'(1);
					end
				end
				FN_POP: begin
					if (held_q == '0) begin
						rsp_nxt.ok = 1'b0;
					end else begin
						rsp_nxt.read_value = FIELD_W'(rd_word);
						held_nxt = held_m1;
					end
				end
				FN_GET_TOP: begin
					ctrl.rd_idx = IDX_W'(held_c - CMP_W'(1) - pos_c);
					rsp_nxt.ok  = !pos_out;
					if (!pos_out)
						rsp_nxt.read_value = FIELD_W'(rd_word);
				end
				FN_GET_BOT: begin
					ctrl.rd_idx = IDX_W'(req.position);
					rsp_nxt.ok  = !pos_out;
					if (!pos_out)
						rsp_nxt.read_value = FIELD_W'(rd_word);
				end
				FN_ROT_UP: begin
					ctrl.load_word = rd_word;
					if (held_q > CNT_W'(1)) begin
						for (int i = 0; i < DEPTH; i++) begin
							if (i == 0)
								ctrl.op[i] = CELL_LOAD;
							else if (CNT_W'(i) < held_q)
								ctrl.op[i] = CELL_DOWN;
						end
					end
				end
				FN_ROT_DN: begin
					ctrl.rd_idx    = '0;
					ctrl.load_word = rd_word;
					if (held_q > CNT_W'(1)) begin
						for (int i = 0; i < DEPTH; i++) begin
							if (CNT_W'(i) == held_m1)
								ctrl.op[i] = CELL_LOAD;
							else if (CNT_W'(i) < held_m1)
								ctrl.op[i] = CELL_UP;
						end
					end
				end
				FN_EXCH: begin
					if (held_q > CNT_W'(1)) begin
						for (int i = 0; i < DEPTH; i++) begin
							if (CNT_W'(i) == held_m1)
								ctrl.op[i] = CELL_DOWN;
							else if (CNT_W'(i) == held_m2)
								ctrl.op[i] = CELL_UP;
						end
					end
				end
				FN_DEL_TOP, FN_DEL_BOT: begin
					if (pos_out)
						held_nxt = '0;
					else
						held_nxt = CNT_W'(held_c - pos_c);
				end
				default: rsp_nxt.ok = 1'b0;
			endcase
		end
		rsp_nxt.count = POS_W'(held_nxt);
	end

	ros_row u_row (
		.clk     (clk),
		.ctrl    (ctrl),
		.rd_word (rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			max_depth_q <= CFG_W'(16);
			held_q      <= '0;
			shift_q     <= '0;
			occ_q       <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_acc) begin
				max_depth_q <= cfg_data;
				if (held_q > new_lim)
					held_q <= new_lim;
			end else if (req_acc) begin
				held_q <= held_nxt;
			end
			if (start_shift)
				shift_q <= CNT_W'(req.position);
			else if (state_q == ST_SHIFT)
				shift_q <= shift_q - CNT_W'(1);
			priority if (req_acc && !rsp_acc)
				occ_q <= occ_q + 2'd1;
			else if (rsp_acc && !req_acc)
				occ_q <= occ_q - 2'd1;
			else
				occ_q <= occ_q;
		end
	end

	// output queue: head is shown, tail waits behind it
	always_ff @(posedge clk) begin
		priority if (req_acc && rsp_acc) begin
			if (occ_q == 2'd2) begin
				head_q <= tail_q;
				tail_q <= rsp_nxt;
			end else begin
				head_q <= rsp_nxt;
			end
		end else if (req_acc) begin
			if (occ_q == 2'd0)
				head_q <= rsp_nxt;
			else
				tail_q <= rsp_nxt;
		end else if (rsp_acc) begin
			head_q <= tail_q;
		end else begin
			head_q <= head_q;
		end
	end

	assign rsp_valid = occ_q != 2'd0;
	assign rsp       = head_q;

endmodule

### src/ros_cell.sv
// ----------------------------------------------------------------------------
// ros_cell
// One stack entry: holds its word, or takes it from a neighbour or the
// shared load word.
// ----------------------------------------------------------------------------
module ros_cell import ros_pkg::*; (
	input  logic                 clk,
	input  ros_cell_op_t         op,
	input  logic [WORD_BITS-1:0] from_up,
	input  logic [WORD_BITS-1:0] from_down,
	input  logic [WORD_BITS-1:0] load_word,
	output logic [WORD_BITS-1:0] word
);

	logic [WORD_BITS-1:0] word_q;

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_HOLD: word_q <= word_q;
			CELL_UP:   word_q <= from_up;
			CELL_DOWN: word_q <= from_down;
			CELL_LOAD: word_q <= load_word;
			default:   word_q <= word_q;
		endcase
	end

	assign word = word_q;

endmodule

### src/ros_row.sv
// ----------------------------------------------------------------------------
// ros_row
// Row of stack cells, bottom entry in cell 0, with the single read port.
// ----------------------------------------------------------------------------
module ros_row import ros_pkg::*; (
	input  logic                 clk,
	input  ros_row_ctrl_t        ctrl,
	output logic [WORD_BITS-1:0] rd_word
);

	logic [WORD_BITS-1:0] words [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_BITS-1:0] up_w;
		logic [WORD_BITS-1:0] down_w;

		if (i < DEPTH - 1) begin : g_up
			assign up_w = words[i+1];
		end else begin : g_up_top
			assign up_w = '0;
		end

		if (i > 0) begin : g_down
			assign down_w = words[i-1];
		end else begin : g_down_bot
			assign down_w = '0;
		end

		ros_cell u_cell (
			.clk       (clk),
			.op        (ctrl.op[i]),
			.from_up   (up_w),
			.from_down (down_w),
			.load_word (ctrl.load_word),
			.word      (words[i])
		);
	end

	assign rd_word = words[ctrl.rd_idx];

endmodule

### bench/ros_stack_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ros_stack_checker
// Watches the request, response and configuration channels of the RPN
// operand stack. It keeps its own copy of the stack and of max_depth,
// works out the answer to every accepted request item, and compares each
// response item in order against the oldest answer still owed.
// ----------------------------------------------------------------------------
module ros_stack_checker import ros_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_stall,
	input  ros_req_t         req,
	input  logic             rsp_valid,
	input  logic             rsp_stall,
	input  ros_rsp_t         rsp,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,
	output int               mismatches,
	output int               pending
);

	logic [WORD_BITS-1:0] stack_mem [DEPTH];
	int                   held;
	logic [CFG_W-1:0]     depth_reg;
	ros_rsp_t             owed_q [$];
	ros_rsp_t             head;
	int                   err_cnt = 0;

	assign mismatches = err_cnt;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("%0t ns: mismatch on %s, got %h, want %h", $realtime, what, got, want);
		err_cnt++;
	endtask

	function automatic int active_limit();
		if (depth_reg == '0 || int'(depth_reg) > DEPTH)
			return DEPTH;
		return int'(depth_reg);
	endfunction

	function automatic void apply_depth(input logic [CFG_W-1:0] v);
		depth_reg = v;
		if (held > active_limit())
			held = active_limit();
	endfunction

	function automatic ros_rsp_t stack_step(input ros_req_t r);
		ros_rsp_t             o;
		int                   lim;
		int                   pos;
		int                   i;
		logic [WORD_BITS-1:0] word;
		logic [WORD_BITS-1:0] rd;
		logic [WORD_BITS-1:0] t;
		lim = active_limit();
		pos = int'(r.position);
		word = r.push_value[WORD_BITS-1:0];
		rd = '0;
		o.ok = 1'b1;
		case (r.func)
			FN_PUSH: begin
				if (held >= lim) begin
					for (i = 0; i + 1 < lim; i++)
						stack_mem[i] = stack_mem[i+1];
					stack_mem[lim-1] = word;
					held = lim;
				end else begin
					stack_mem[held] = word;
					held++;
				end
			end
			FN_POP: begin
				if (held == 0) begin
					o.ok = 1'b0;
				end else begin
					held--;
					rd = stack_mem[held];
				end
			end
			FN_GET_TOP: begin
				if (pos >= held)
					o.ok = 1'b0;
				else
					rd = stack_mem[held-1-pos];
			end
			FN_GET_BOT: begin
				if (pos >= held)
					o.ok = 1'b0;
				else
					rd = stack_mem[pos];
			end
			FN_ROT_UP: begin
				if (held > 1) begin
					t = stack_mem[held-1];
					for (i = held - 1; i > 0; i--)
						stack_mem[i] = stack_mem[i-1];
					stack_mem[0] = t;
				end
			end
			FN_ROT_DN: begin
				if (held > 1) begin
					t = stack_mem[0];
					for (i = 0; i + 1 < held; i++)
						stack_mem[i] = stack_mem[i+1];
					stack_mem[held-1] = t;
				end
			end
			FN_EXCH: begin
				if (held > 1) begin
					t = stack_mem[held-1];
					stack_mem[held-1] = stack_mem[held-2];
					stack_mem[held-2] = t;
				end
			end
			FN_DEL_TOP: begin
				if (pos >= held)
					held = 0;
				else
					held -= pos;
			end
			FN_DEL_BOT: begin
				if (pos >= held) begin
					held = 0;
				end else begin
					for (i = 0; i + pos < held; i++)
						stack_mem[i] = stack_mem[i+pos];
					held -= pos;
				end
			end
			default: o.ok = 1'b0;
		endcase
		o.read_value = '0;
		o.read_value[WORD_BITS-1:0] = rd;
		o.count = POS_W'(held);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++)
				stack_mem[k] = '0;
			held = 0;
			depth_reg = CFG_W'(16);
			owed_q.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_depth(cfg_data);
			if (req_valid && !req_stall)
				owed_q.push_back(stack_step(req));
			if (rsp_valid && !rsp_stall) begin
				if (owed_q.size() == 0) begin
					report("response item with none owed", rsp.read_value, '0);
				end else begin
					head = owed_q.pop_front();
					if (rsp.read_value !== head.read_value)
						report("read_value", rsp.read_value, head.read_value);
					if (rsp.ok !== head.ok)
						report("ok", 64'(rsp.ok), 64'(head.ok));
					if (rsp.count !== head.count)
						report("count", 64'(rsp.count), 64'(head.count));
				end
			end
			pending <= owed_q.size();
		end
	end

endmodule

### bench/rpn_operand_stack_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rpn_operand_stack_tb
// Drives the RPN operand stack with a directed run over corner cases and
// then random operations under several max_depth settings, with random idle
// cycles on both channels but in the last three. A checker beside the block
// predicts and compares every response item; this module gives the verdict.
// ----------------------------------------------------------------------------
module rpn_operand_stack_tb;
	import ros_pkg::*;

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	ros_req_t         req       = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	ros_rsp_t         rsp;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data  = '0;

	int mismatches;
	int pending;
	int snd_idle = 0;
	int rcv_idle = 0;
	int seg_depth [11] = '{16, 1, 2, 0, 31, 7, 3, 17, 16, 12, 0};

	rpn_operand_stack DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	ros_stack_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < rcv_idle);
	end

	initial begin
		#4000000;
		$display("FAIL");
		$finish;
	end

	task automatic send(input ros_req_t r);
		while ($urandom_range(99) < snd_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic issue(input logic [FUNC_W-1:0] f, input logic [63:0] v,
			input logic [POS_W-1:0] p);
		ros_req_t r;
		r.func = ros_func_t'(f);
		r.push_value = v;
		r.position = p;
		send(r);
	endtask

	// hold off until every owed response item has arrived
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_depth(input logic [CFG_W-1:0] v);
		drain();
		repeat (20) @(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic ros_req_t random_item();
		ros_req_t r;
		int       pick;
		pick = $urandom_range(99);
		if (pick < 34)
			r.func = FN_PUSH;
		else if (pick < 44)
			r.func = FN_POP;
		else if (pick < 54)
			r.func = FN_GET_TOP;
		else if (pick < 64)
			r.func = FN_GET_BOT;
		else if (pick < 70)
			r.func = FN_ROT_UP;
		else if (pick < 76)
			r.func = FN_ROT_DN;
		else if (pick < 82)
			r.func = FN_EXCH;
		else if (pick < 88)
			r.func = FN_DEL_TOP;
		else if (pick < 95)
			r.func = FN_DEL_BOT;
		else
			r.func = ros_func_t'($urandom_range(15, 9));
		case ($urandom_range(19))
			0:       r.push_value = '0;
			1:       r.push_value = '1;
			default: r.push_value = {$urandom(), $urandom()};
		endcase
		if ($urandom_range(9) == 0)
			r.position = POS_W'($urandom_range(31));
		else if (r.func == FN_DEL_TOP || r.func == FN_DEL_BOT)
			r.position = POS_W'($urandom_range(3));
		else
			r.position = POS_W'($urandom_range(16));
		return r;
	endfunction

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		snd_idle = 17;
		rcv_idle = 72;

		issue(FN_POP, '0, '0);
		issue(FN_GET_TOP, '0, '0);
		issue(FN_ROT_UP, '0, '0);
		issue(FN_EXCH, '0, '0);
		issue(FN_DEL_BOT, '0, 5'd2);
		issue(FN_PUSH, '0, '0);
		issue(FN_PUSH, '1, 5'd31);
		issue(FN_PUSH, 64'h0123_4567_89ab_cdef, '0);
		issue(FN_EXCH, '0, '0);
		issue(FN_ROT_UP, '0, '0);
		issue(FN_ROT_DN, '0, '0);
		issue(FN_GET_TOP, '0, '0);
		issue(FN_GET_BOT, '0, 5'd2);
		issue(FN_GET_TOP, '0, 5'd16);
		issue(FN_GET_BOT, '0, 5'd31);
		issue(4'd9, '1, '0);
		issue(4'd15, '1, 5'd31);
		issue(FN_DEL_BOT, '0, 5'd1);
		issue(FN_DEL_TOP, '0, '0);
		issue(FN_DEL_TOP, '0, 5'd31);

		write_depth(5'd2);
		issue(FN_PUSH, 64'h1, '0);
		issue(FN_PUSH, 64'h2, '0);
		issue(FN_PUSH, 64'h3, '0);
		issue(FN_GET_BOT, '0, '0);
		write_depth(5'd1);
		issue(FN_PUSH, 64'h4, '0);
		issue(FN_POP, '0, '0);

		for (int seg = 0; seg < 11; seg++) begin
			if (seg < 4) begin
				snd_idle = 17;
				rcv_idle = 72;
			end else if (seg < 8) begin
				snd_idle = 72;
				rcv_idle = 17;
			end else begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			write_depth(seg == 10 ? CFG_W'($urandom_range(31)) : CFG_W'(seg_depth[seg]));
			for (int n = 0; n < 150; n++) begin
				if ($urandom_range(199) == 0)
					drain();
				send(random_item());
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
